### hw/rtl/mfr_pkg.sv
// ----------------------------------------------------------------------------
// mfr_pkg
// Shared codes, byte constants and controller/datapath bundles for the modem
// serial frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mfr_pkg;

  // input beat opcodes
  typedef enum logic [1:0] {
    OP_RX_BYTE   = 2'd0,
    OP_SENT      = 2'd1,
    OP_LINK_FAIL = 2'd2,
    OP_IGNORE    = 2'd3
  } opcode_t;

  // result kinds
  typedef enum logic [2:0] {
    KIND_ACK    = 3'd0,
    KIND_NACK   = 3'd1,
    KIND_ERR    = 3'd2,
    KIND_NOTIFY = 3'd3,
    KIND_BUSY   = 3'd4
  } kind_t;

  localparam logic [7:0] BYTE_STX    = 8'h02;
  localparam logic [7:0] BYTE_NAK    = 8'h15;
  localparam logic [7:0] CMD_STD_RX  = 8'h60;
  localparam logic [7:0] CMD_ECHO    = 8'h62;
  localparam logic [7:0] CMD_NOTIFY  = 8'h50;
  localparam logic [7:0] HI_MASK     = 8'hf0;
  localparam logic [7:0] HI_ACK_A    = 8'h60;
  localparam logic [7:0] HI_ACK_B    = 8'h70;
  localparam logic [7:0] NOTIFY_MASK = 8'h50;

  // payload bytes after the command byte
  localparam int LEN_STD_RX = 7;
  localparam int LEN_NOTIFY = 9;

  // cap on replies that can be emitted for one frame
  localparam int MAX_RESULTS = 32;

  // controller -> datapath
  typedef struct packed {
    logic  cmd_load;     // capture command byte, set expected length
    logic  first_load;   // capture first byte after command
    logic  data_load;    // capture payload byte at byte count
    logic  bc_clear;
    logic  pend_load;
    logic  pend_clear;
    logic  single_emit;  // one-beat result with zero data
    kind_t single_kind;
    logic  dump_start;
    logic  dump_ack;     // 1: ack readout, 0: notify readout
    logic  dump_read;
    logic  dump_emit;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pend_valid;
    logic byte_stx;
    logic cmd_known;
    logic nack_hit;
    logic first_done;
    logic data_done;
    logic ack_match;
    logic notify_match;
    logic dump_last;
    logic out_free;
  } ctl_stat_t;

endpackage

`default_nettype wire

### hw/rtl/mfr_intf.sv
// ----------------------------------------------------------------------------
// mfr channel interfaces
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;
  logic [7:0] sent_number;
  logic [5:0] sent_length;

  modport source (output valid, output opcode, output rx_byte, output sent_number,
                  output sent_length, input ready);
  modport sink   (input valid, input opcode, input rx_byte, input sent_number,
                  input sent_length, output ready);
endinterface

interface mfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data;
  logic       last;

  modport source (output valid, output kind, output data, output last, input ready);
  modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/mfr_datapath.sv
// ----------------------------------------------------------------------------
// mfr_datapath
// Frame store, byte counter, pending command, readout pointer and the
// output register. Acts on controller commands, reports status flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mfr_datapath import mfr_pkg::*; #(
  parameter int MAX_FRAME = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctl_cmd_t   cmd,
  output ctl_stat_t  stat,
  input  logic [7:0] rx_byte,
  input  logic [7:0] sent_number,
  input  logic [5:0] sent_length,
  output logic       out_valid,
  input  logic       out_ready,
  output kind_t      out_kind,
  output logic [7:0] out_data,
  output logic       out_last
);

  localparam int AW  = $clog2(MAX_FRAME);
  localparam int CW  = $clog2(MAX_FRAME + 1);
  localparam int CAP = (MAX_FRAME - 1 < MAX_RESULTS) ? (MAX_FRAME - 1) : MAX_RESULTS;

  logic [7:0]    mem [MAX_FRAME];
  logic [7:0]    rd_data_r;

  logic [7:0]    cmd_r,       cmd_nxt;
  logic [AW-1:0] expected_r,  expected_nxt;
  logic [CW-1:0] bc_r,        bc_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [7:0]    pend_num_r,  pend_num_nxt;
  logic [5:0]    pend_len_r,  pend_len_nxt;
  logic [AW-1:0] idx_r,       idx_nxt;
  logic [AW-1:0] last_idx_r,  last_idx_nxt;
  kind_t         dump_kind_r, dump_kind_nxt;
  logic          out_valid_r, out_valid_nxt;
  kind_t         out_kind_r,  out_kind_nxt;
  logic [7:0]    out_data_r,  out_data_nxt;
  logic          out_last_r,  out_last_nxt;

  logic [AW-1:0] clamp_len;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;

  // echo length: zero counts as one, long lengths saturate
  always_comb begin
    if (pend_len_r == 6'd0) begin
      clamp_len = AW'(1);
    end else if ({1'b0, pend_len_r} > 7'(CAP)) begin
      clamp_len = AW'(CAP);
    end else begin
      clamp_len = AW'(pend_len_r);
    end
  end

  always_comb begin
    stat.pend_valid   = pend_valid_r;
    stat.byte_stx     = (rx_byte == BYTE_STX);
    stat.cmd_known    = (rx_byte == CMD_STD_RX) || (rx_byte == CMD_NOTIFY) ||
                        ((rx_byte == CMD_ECHO) && pend_valid_r);
    stat.nack_hit     = pend_valid_r && (pend_num_r == cmd_r) && (rx_byte == BYTE_NAK);
    stat.first_done   = (expected_r < AW'(2));
    stat.data_done    = (bc_r >= CW'(expected_r));
    stat.ack_match    = (((cmd_r & HI_MASK) == HI_ACK_A) || ((cmd_r & HI_MASK) == HI_ACK_B))
                        && pend_valid_r && (pend_num_r == cmd_r);
    stat.notify_match = ((cmd_r & NOTIFY_MASK) == NOTIFY_MASK);
    stat.dump_last    = (idx_r == last_idx_r);
    stat.out_free     = !out_valid_r || out_ready;
  end

  always_comb begin
    cmd_nxt        = cmd_r;
    expected_nxt   = expected_r;
    bc_nxt         = bc_r;
    pend_valid_nxt = pend_valid_r;
    pend_num_nxt   = pend_num_r;
    pend_len_nxt   = pend_len_r;
    idx_nxt        = idx_r;
    last_idx_nxt   = last_idx_r;
    dump_kind_nxt  = dump_kind_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;

    if (cmd.cmd_load) begin
      cmd_nxt   = rx_byte;
      mem_we    = 1'b1;
      mem_waddr = '0;
      if (rx_byte == CMD_STD_RX) begin
        expected_nxt = AW'(LEN_STD_RX);
      end else if (rx_byte == CMD_NOTIFY) begin
        expected_nxt = AW'(LEN_NOTIFY);
      end else if ((rx_byte == CMD_ECHO) && pend_valid_r) begin
        expected_nxt = clamp_len;
      end
    end
    if (cmd.first_load) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(1);
      bc_nxt    = CW'(2);
    end
    if (cmd.data_load) begin
      mem_we    = 1'b1;
      mem_waddr = bc_r[AW-1:0];
      bc_nxt    = bc_r + CW'(1);
    end
    if (cmd.bc_clear) begin
      bc_nxt = '0;
    end

    if (cmd.pend_load) begin
      pend_valid_nxt = 1'b1;
      pend_num_nxt   = sent_number;
      pend_len_nxt   = sent_length;
    end
    if (cmd.pend_clear) begin
      pend_valid_nxt = 1'b0;
    end

    if (cmd.dump_start) begin
      idx_nxt = '0;
      if (cmd.dump_ack) begin
        last_idx_nxt  = expected_nxt - AW'(1);
        dump_kind_nxt = KIND_ACK;
      end else begin
        last_idx_nxt  = expected_nxt;
        dump_kind_nxt = KIND_NOTIFY;
      end
    end

    if (cmd.single_emit) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = cmd.single_kind;
      out_data_nxt  = 8'h00;
      out_last_nxt  = 1'b1;
    end else if (cmd.dump_emit) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = dump_kind_r;
      out_data_nxt  = rd_data_r;
      out_last_nxt  = (idx_r == last_idx_r);
      idx_nxt       = idx_r + AW'(1);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= rx_byte;
    end
    if (cmd.dump_read) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r        <= '0;
      expected_r   <= '0;
      bc_r         <= '0;
      pend_valid_r <= 1'b0;
      pend_num_r   <= '0;
      pend_len_r   <= '0;
      idx_r        <= '0;
      last_idx_r   <= '0;
      dump_kind_r  <= KIND_ACK;
      out_valid_r  <= 1'b0;
    end else begin
      cmd_r        <= cmd_nxt;
      expected_r   <= expected_nxt;
      bc_r         <= bc_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_num_r   <= pend_num_nxt;
      pend_len_r   <= pend_len_nxt;
      idx_r        <= idx_nxt;
      last_idx_r   <= last_idx_nxt;
      dump_kind_r  <= dump_kind_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

### hw/rtl/mfr_ctrl.sv
// ----------------------------------------------------------------------------
// mfr_ctrl
// Parser state machine: frame phases plus a two-step readout loop that
// streams a completed frame out of the store.
// ----------------------------------------------------------------------------
`default_nettype none

module mfr_ctrl import mfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  ctl_stat_t  stat,
  output ctl_cmd_t   cmd
);

  typedef enum logic [5:0] {
    ST_STX   = 6'b000001,
    ST_CMD   = 6'b000010,
    ST_FIRST = 6'b000100,
    ST_DATA  = 6'b001000,
    ST_RD    = 6'b010000,
    ST_WR    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   parsing;
  logic   in_fire;
  logic   complete;

  assign parsing  = (state_r == ST_STX) || (state_r == ST_CMD) ||
                    (state_r == ST_FIRST) || (state_r == ST_DATA);
  assign in_ready = parsing && stat.out_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    complete  = 1'b0;

    if (in_fire) begin
      unique case (opcode)
        OP_SENT: begin
          if (stat.pend_valid) begin
            cmd.single_emit = 1'b1;
            cmd.single_kind = KIND_BUSY;
          end else begin
            cmd.pend_load = 1'b1;
          end
        end
        OP_LINK_FAIL: begin
          state_nxt    = ST_STX;
          cmd.bc_clear = 1'b1;
          if (stat.pend_valid) begin
            cmd.pend_clear  = 1'b1;
            cmd.single_emit = 1'b1;
            cmd.single_kind = KIND_ERR;
          end
        end
        OP_RX_BYTE: begin
          if (state_r == ST_STX) begin
            if (stat.byte_stx) begin
              state_nxt = ST_CMD;
            end
          end else if (state_r == ST_CMD) begin
            cmd.cmd_load = 1'b1;
            state_nxt    = stat.cmd_known ? ST_FIRST : ST_STX;
          end else if (state_r == ST_FIRST) begin
            cmd.first_load = 1'b1;
            if (stat.nack_hit) begin
              cmd.pend_clear  = 1'b1;
              cmd.single_emit = 1'b1;
              cmd.single_kind = KIND_NACK;
              cmd.bc_clear    = 1'b1;
              state_nxt       = ST_STX;
            end else if (stat.first_done) begin
              complete = 1'b1;
            end else begin
              state_nxt = ST_DATA;
            end
          end else begin
            cmd.data_load = 1'b1;
            complete      = stat.data_done;
          end
        end
        default: ;
      endcase
    end

    // frame end: ack and notify are exclusive for the command bytes kept
    if (complete) begin
      cmd.bc_clear = 1'b1;
      if (stat.ack_match) begin
        cmd.dump_start = 1'b1;
        cmd.dump_ack   = 1'b1;
        cmd.pend_clear = 1'b1;
        state_nxt      = ST_RD;
      end else if (stat.notify_match) begin
        cmd.dump_start = 1'b1;
        state_nxt      = ST_RD;
      end else begin
        state_nxt = ST_STX;
      end
    end

    if (state_r == ST_RD) begin
      cmd.dump_read = 1'b1;
      state_nxt     = ST_WR;
    end else if (state_r == ST_WR) begin
      if (stat.out_free) begin
        cmd.dump_emit = 1'b1;
        state_nxt     = stat.dump_last ? ST_STX : ST_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_STX;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/modem_serial_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// modem_serial_frame_receiver_top
// Parses STX-framed modem replies against one pending outgoing command and
// reports ack data, nack, error, notify and busy results.
// ----------------------------------------------------------------------------
//  channel | dir | beat content
//  in_ch   | in  | opcode, rx_byte, sent_number, sent_length
//  out_ch  | out | kind, data, last
//
//  An input beat is taken whenever the parser is not reading out a frame
//  and the output register is free or draining. A completed ack or notify
//  frame is read out of the store result by result (registered store read,
//  then output load); input waits for the readout and any out_ch stalls.
//  Reset is synchronous, active low; the frame store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module modem_serial_frame_receiver_top import mfr_pkg::*; #(
  parameter int MAX_FRAME = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  mfr_in_if.sink    in_ch,
  mfr_out_if.source out_ch
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;
  kind_t     out_kind;

  mfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .opcode   (in_ch.opcode),
    .stat     (stat),
    .cmd      (cmd)
  );

  mfr_datapath #(
    .MAX_FRAME (MAX_FRAME)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .rx_byte     (in_ch.rx_byte),
    .sent_number (in_ch.sent_number),
    .sent_length (in_ch.sent_length),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_kind    (out_kind),
    .out_data    (out_ch.data),
    .out_last    (out_ch.last)
  );

  assign out_ch.kind = out_kind;

endmodule

`default_nettype wire

### tb/mfr_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mfr_frame_checker
// Watches both channels of the modem frame receiver. Every accepted input
// beat runs through a behavioral frame parser that queues the replies it
// should cause; every accepted output beat is compared field by field with
// the oldest queued reply.
// ----------------------------------------------------------------------------

module mfr_frame_checker import mfr_pkg::*; #(
  parameter int MAX_FRAME = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  mfr_in_if                in_ch,
  mfr_out_if               out_ch,
  output int               fail_count,
  output int               expect_left,
  output int               beats_in,
  output logic [4:0][15:0] kind_tally
);

  typedef enum logic [1:0] {
    PH_STX,
    PH_CMD,
    PH_FIRST,
    PH_DATA
  } parse_phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } reply_t;

  // parser state
  parse_phase_t ph;
  logic [7:0]   frame_mem [0:MAX_FRAME-1];
  int unsigned  byte_cnt;
  int unsigned  want_len;
  logic         pend_v;
  logic [7:0]   pend_num;
  logic [5:0]   pend_len;

  reply_t step_q[$];
  reply_t reply_q[$];

  int               n_bad = 0;
  int               n_in  = 0;
  logic [4:0][15:0] tally;

  function automatic int unsigned echo_payload_len(logic [5:0] len);
    int unsigned cap;
    int unsigned l;
    cap = (MAX_FRAME - 1 < MAX_RESULTS) ? MAX_FRAME - 1 : MAX_RESULTS;
    l = 32'(len);
    if (l < 1) l = 1;
    if (l > cap) l = cap;
    return l;
  endfunction

  task automatic queue_reply(kind_t k, logic [7:0] d);
    reply_t r;
    r.kind = k;
    r.data = d;
    r.last = 1'b0;
    step_q.push_back(r);
  endtask

  // frame done: ack readout drops the trailing ack byte, notify goes out whole
  task automatic close_frame();
    logic [7:0] cmd;
    cmd = frame_mem[0];
    if (((cmd & HI_MASK) == HI_ACK_A || (cmd & HI_MASK) == HI_ACK_B) &&
        pend_v && pend_num == cmd) begin
      for (int i = 0; i < want_len; i++) queue_reply(KIND_ACK, frame_mem[i]);
      pend_v = 1'b0;
    end
    if ((cmd & NOTIFY_MASK) == NOTIFY_MASK) begin
      for (int i = 0; i <= want_len && step_q.size() < MAX_RESULTS; i++)
        queue_reply(KIND_NOTIFY, frame_mem[i]);
    end
    ph = PH_STX;
    byte_cnt = 0;
  endtask

  task automatic parse_beat(logic [1:0] op, logic [7:0] b, logic [7:0] num,
                            logic [5:0] len);
    reply_t r;
    step_q.delete();
    case (opcode_t'(op))
      OP_SENT: begin
        if (pend_v) begin
          queue_reply(KIND_BUSY, 8'h00);
        end else begin
          pend_v = 1'b1;
          pend_num = num;
          pend_len = len;
        end
      end
      OP_LINK_FAIL: begin
        ph = PH_STX;
        byte_cnt = 0;
        if (pend_v) begin
          pend_v = 1'b0;
          queue_reply(KIND_ERR, 8'h00);
        end
      end
      OP_RX_BYTE: begin
        case (ph)
          PH_STX: begin
            if (b == BYTE_STX) ph = PH_CMD;
          end
          PH_CMD: begin
            frame_mem[0] = b;
            ph = PH_FIRST;
            if (b == CMD_STD_RX) want_len = LEN_STD_RX;
            else if (b == CMD_NOTIFY) want_len = LEN_NOTIFY;
            else if (b == CMD_ECHO && pend_v) want_len = echo_payload_len(pend_len);
            else ph = PH_STX;
          end
          PH_FIRST: begin
            frame_mem[1] = b;
            if (pend_v && pend_num == frame_mem[0] && b == BYTE_NAK) begin
              pend_v = 1'b0;
              ph = PH_STX;
              byte_cnt = 0;
              queue_reply(KIND_NACK, 8'h00);
            end else begin
              byte_cnt = 2;
              if (byte_cnt > want_len) close_frame();
              else ph = PH_DATA;
            end
          end
          default: begin
            if (byte_cnt < MAX_FRAME) begin
              frame_mem[byte_cnt] = b;
              byte_cnt++;
            end
            if (byte_cnt > want_len || byte_cnt >= MAX_FRAME) close_frame();
          end
        endcase
      end
      default: ;
    endcase
    for (int i = 0; i < step_q.size(); i++) begin
      r = step_q[i];
      r.last = (i == step_q.size() - 1);
      reply_q.push_back(r);
    end
  endtask

  task automatic check_reply();
    reply_t want;
    if (reply_q.size() == 0) begin
      $error("result with nothing expected: kind %0d data 0x%02h last %0b",
             out_ch.kind, out_ch.data, out_ch.last);
      n_bad++;
    end else begin
      want = reply_q.pop_front();
      if (out_ch.kind !== want.kind) begin
        $error("field kind: expected %0d, actual %0d", want.kind, out_ch.kind);
        n_bad++;
      end
      if (out_ch.data !== want.data) begin
        $error("field data: expected 0x%02h, actual 0x%02h", want.data, out_ch.data);
        n_bad++;
      end
      if (out_ch.last !== want.last) begin
        $error("field last: expected %0b, actual %0b", want.last, out_ch.last);
        n_bad++;
      end
    end
    if (out_ch.kind <= KIND_BUSY) tally[out_ch.kind] = tally[out_ch.kind] + 16'd1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ph = PH_STX;
      byte_cnt = 0;
      want_len = 0;
      pend_v = 1'b0;
      pend_num = 8'h00;
      pend_len = 6'd0;
      reply_q.delete();
      tally = '0;
    end else begin
      // input first, so a same-edge reply could never look unexpected
      if (in_ch.valid && in_ch.ready) begin
        parse_beat(in_ch.opcode, in_ch.rx_byte, in_ch.sent_number, in_ch.sent_length);
        n_in++;
      end
      if (out_ch.valid && out_ch.ready) check_reply();
    end
    fail_count  <= n_bad;
    expect_left <= reply_q.size();
    beats_in    <= n_in;
    kind_tally  <= tally;
  end

endmodule

### tb/tb_modem_serial_frame_receiver_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modem_serial_frame_receiver_top
// Drives the modem frame receiver with a short directed set, then with
// random command/reply exchanges, notify frames and line noise, under bursty
// input and a stalling output with one long hold-off. The checker beside
// the block predicts and compares all replies; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_modem_serial_frame_receiver_top;
  import mfr_pkg::*;

  localparam int MAX_FRAME    = 32;
  localparam int N_ITEMS      = 270;
  localparam int LONG_HOLD    = 500;
  localparam int DRAIN_CYCLES = 2 * MAX_RESULTS + 64;

  logic clk = 1'b0;
  logic rst_n;

  mfr_in_if  in_ch ();
  mfr_out_if out_ch ();

  int               fail_count;
  int               expect_left;
  int               beats_in;
  logic [4:0][15:0] kind_tally;

  int unsigned burst_left = 0;
  int          sent_items = 0;
  bit          hold_req   = 1'b0;

  modem_serial_frame_receiver_top #(.MAX_FRAME(MAX_FRAME)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mfr_frame_checker #(.MAX_FRAME(MAX_FRAME)) i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .expect_left (expect_left),
    .beats_in    (beats_in),
    .kind_tally  (kind_tally)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // output side: random stall modes, plus one long hold-off once asked
  initial begin
    int mode;
    int left;
    int cyc;
    bit held;
    mode = 0;
    left = 0;
    cyc = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 120);
        end
        left--;
        cyc++;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ((cyc % 5) >= 2);
        endcase
        @(posedge clk);
      end
    end
  end

  // one beat, sender idles between bursts of random length
  task automatic send_beat(opcode_t op, logic [7:0] b, logic [7:0] num, logic [5:0] len);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.rx_byte     <= b;
    in_ch.sent_number <= num;
    in_ch.sent_length <= len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op != OP_IGNORE) sent_items++;
  endtask

  task automatic put_byte(logic [7:0] b);
    send_beat(OP_RX_BYTE, b, 8'($urandom), 6'($urandom));
  endtask

  task automatic post_command(logic [7:0] num, logic [5:0] len);
    send_beat(OP_SENT, 8'($urandom), num, len);
  endtask

  task automatic drop_link();
    send_beat(OP_LINK_FAIL, 8'($urandom), 8'($urandom), 6'($urandom));
  endtask

  // STX, command, n payload bytes; first byte kept off NAK
  task automatic put_frame(logic [7:0] cmd, int unsigned n);
    logic [7:0] b;
    put_byte(BYTE_STX);
    put_byte(cmd);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (i == 0 && b == BYTE_NAK) b = ~b;
      put_byte(b);
    end
  endtask

  // record a command, then answer it the way the modem would (mostly)
  task automatic run_exchange();
    logic [7:0]  num;
    logic [5:0]  len;
    int unsigned plen;
    int          r;
    r = $urandom_range(0, 19);
    if (r < 9) num = CMD_ECHO;
    else if (r < 15) num = CMD_STD_RX;
    else if (r < 17) num = CMD_NOTIFY;
    else num = 8'($urandom);
    r = $urandom_range(0, 19);
    if (r < 13) len = 6'($urandom_range(1, 10));
    else if (r < 14) len = 6'd0;
    else if (r < 17) len = 6'($urandom_range(11, 31));
    else len = 6'($urandom_range(32, 63));
    plen = (len == 0) ? 1 : ((len > MAX_FRAME - 1) ? MAX_FRAME - 1 : len);
    if (num == CMD_STD_RX) plen = LEN_STD_RX;

    post_command(num, len);
    r = $urandom_range(0, 19);
    if (num == CMD_STD_RX || num == CMD_ECHO) begin
      if (r < 12) begin
        put_frame(num, plen);
      end else if (r < 15) begin
        put_byte(BYTE_STX);
        put_byte(num);
        put_byte(BYTE_NAK);
      end else if (r < 17) begin
        put_frame(CMD_NOTIFY, LEN_NOTIFY);
        put_frame(num, plen);
      end else if (r < 18) begin
        drop_link();
      end else begin
        post_command(8'($urandom), 6'($urandom));
        put_frame(num, plen);
      end
    end else if (num == CMD_NOTIFY) begin
      if (r < 10) begin
        put_byte(BYTE_STX);
        put_byte(num);
        put_byte(BYTE_NAK);
      end else begin
        put_frame(CMD_NOTIFY, LEN_NOTIFY);
        drop_link();
      end
    end else begin
      if (r < 8) post_command(8'($urandom), 6'($urandom));
      drop_link();
    end
  endtask

  // stray bytes, ignored beats, odd commands, cut-off frames; link drop resyncs
  task automatic put_noise();
    int k;
    logic [7:0] b;
    k = $urandom_range(1, 6);
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(0, 7))
        0: send_beat(OP_IGNORE, 8'($urandom), 8'($urandom), 6'($urandom));
        1: post_command(8'($urandom), 6'($urandom));
        7: begin
          put_byte(BYTE_STX);
          put_byte(CMD_STD_RX);
          repeat ($urandom_range(0, 5)) put_byte(8'($urandom));
        end
        default: begin
          case ($urandom_range(0, 5))
            0: b = BYTE_STX;
            1: b = CMD_STD_RX;
            2: b = CMD_ECHO;
            3: b = CMD_NOTIFY;
            4: b = BYTE_NAK;
            default: b = 8'($urandom);
          endcase
          put_byte(b);
        end
      endcase
    end
    drop_link();
  endtask

  initial begin
    int pick;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_IGNORE;
    in_ch.rx_byte     <= 8'h00;
    in_ch.sent_number <= 8'h00;
    in_ch.sent_length <= 6'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: ignored beat, idle link drop, zero length echo,
    // busy then nack, error on link drop, echo with nothing pending, notify
    send_beat(OP_IGNORE, 8'hff, 8'hff, 6'h3f);
    drop_link();
    post_command(CMD_ECHO, 6'd0);
    put_byte(BYTE_STX);
    put_byte(CMD_ECHO);
    put_byte(8'hff);
    post_command(CMD_STD_RX, 6'h3f);
    post_command(8'h00, 6'd1);
    put_byte(BYTE_STX);
    put_byte(CMD_STD_RX);
    put_byte(BYTE_NAK);
    post_command(8'hff, 6'd32);
    drop_link();
    put_byte(BYTE_STX);
    put_byte(CMD_ECHO);
    put_byte(BYTE_STX);
    put_byte(CMD_NOTIFY);
    for (int i = 0; i < LEN_NOTIFY; i++) put_byte(i[0] ? 8'hff : 8'h00);

    while (sent_items < N_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) run_exchange();
      else if (pick < 8) put_frame(CMD_NOTIFY, LEN_NOTIFY);
      else put_noise();
      if (sent_items > 80) hold_req = 1'b1;
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (expect_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input beats: directed set, exchanges, notify frames, noise, %s",
             beats_in, "one long output hold-off");
    $display("Results seen: ack %0d, nack %0d, error %0d, notify %0d, busy %0d",
             kind_tally[KIND_ACK], kind_tally[KIND_NACK], kind_tally[KIND_ERR],
             kind_tally[KIND_NOTIFY], kind_tally[KIND_BUSY]);
    if (fail_count == 0 && expect_left == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
